// ===== rtl/spritz_absorb_squeeze_unit_assert.svh =====
// assertion macros for the spritz absorb/squeeze unit checker
// expects i_clk and i_rst_n in the scope where they are used
`ifndef SPRITZ_ABSORB_SQUEEZE_UNIT_ASSERT_SVH
`define SPRITZ_ABSORB_SQUEEZE_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define SAS_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("sas assertion failed");

// next-cycle implication, off during reset
`define SAS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("sas assertion failed");

// next-cycle implication, also checked through reset
`define SAS_ASSERT_NEXT_RST(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (cons)) \
        else $error("sas assertion failed");

`endif

// ===== rtl/sas_pkg.sv =====
// shared constants, op codes and control structs for the spritz unit
// no dependencies
`timescale 1ns / 1ps

package sas_pkg;

    localparam int PERM_SIZE = 256;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int OP_W      = 5;

    // request codes
    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_ABS  = 2'd1;
    localparam logic [1:0] ACT_DRIP = 2'd2;

    // datapath micro-ops
    localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
    localparam logic [OP_W-1:0] OP_INIT  = 5'd1;
    localparam logic [OP_W-1:0] OP_U0    = 5'd2;
    localparam logic [OP_W-1:0] OP_U1    = 5'd3;
    localparam logic [OP_W-1:0] OP_U2    = 5'd4;
    localparam logic [OP_W-1:0] OP_U3    = 5'd5;
    localparam logic [OP_W-1:0] OP_U4    = 5'd6;
    localparam logic [OP_W-1:0] OP_WSTEP = 5'd7;
    localparam logic [OP_W-1:0] OP_C0    = 5'd8;
    localparam logic [OP_W-1:0] OP_C1    = 5'd9;
    localparam logic [OP_W-1:0] OP_C2    = 5'd10;
    localparam logic [OP_W-1:0] OP_C3    = 5'd11;
    localparam logic [OP_W-1:0] OP_A0    = 5'd12;
    localparam logic [OP_W-1:0] OP_A1    = 5'd13;
    localparam logic [OP_W-1:0] OP_A2    = 5'd14;
    localparam logic [OP_W-1:0] OP_A3    = 5'd15;
    localparam logic [OP_W-1:0] OP_D0    = 5'd16;
    localparam logic [OP_W-1:0] OP_D1    = 5'd17;
    localparam logic [OP_W-1:0] OP_D2    = 5'd18;
    localparam logic [OP_W-1:0] OP_D3    = 5'd19;

    localparam logic [IDX_W-1:0] HALF_IDX = 8'd128;
    localparam logic [CNT_W-1:0] WHIP_LAST = 9'd511;
    localparam logic [6:0]       CRUSH_LAST = 7'd127;
    localparam logic [2:0]       PHASE_LAST = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_clr;
        logic            cnt_inc;
        logic            a_clr;
        logic            key_ld;
        logic            hi;
    } t_cmd;

    typedef struct packed {
        logic a_full;
        logic a_zero;
        logic whip_last;
        logic crush_last;
    } t_sts;

endpackage

// ===== rtl/sas_if.sv =====
// request and keystream channel interfaces
// depends on nothing but the package widths being 2/8/8
`timescale 1ns / 1ps

interface sas_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] key_byte;
    modport source (output valid, output action, output key_byte, input ready);
    modport sink   (input valid, input action, input key_byte, output ready);
endinterface

interface sas_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] random_byte;
    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface

// ===== rtl/sas_dpath.sv =====
// spritz datapath: permutation memory, index registers, loop counter
// depends on sas_pkg
`timescale 1ns / 1ps

module sas_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sas_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_key_byte,
    output sas_pkg::t_sts       o_sts,
    output logic [7:0]          o_random_byte
);

    logic [7:0] mem [sas_pkg::PERM_SIZE];
    logic [sas_pkg::PERM_SIZE-1:0] r_vld;

    logic [7:0] r_i, r_j, r_k, r_w, r_a, r_z, r_t, r_key, r_out;
    logic       r_sw;
    logic [sas_pkg::CNT_W-1:0] r_cnt;
    logic [7:0] r_rd_mem, r_rd_addr;
    logic       r_rd_vld;

    logic [7:0] s_val, s_nib_addr, s_v, rd_addr, wr_addr, wr_data;
    logic       rd_en, wr_en;

    // read value: entries never written since init hold their own index
    assign s_val = r_rd_vld ? r_rd_mem : r_rd_addr;
    assign s_nib_addr = sas_pkg::HALF_IDX + {4'd0, (i_cmd.hi ? r_key[7:4] : r_key[3:0])};
    assign s_v = {1'b0, r_cnt[6:0]};

    // address and write port selection
    always_comb begin
        rd_en = 1'b1;
        rd_addr = r_i + r_w;
        wr_en = 1'b0;
        wr_addr = r_i;
        wr_data = s_val;
        case (i_cmd.op)
            sas_pkg::OP_U0: rd_addr = r_i + r_w;
            sas_pkg::OP_U1: rd_addr = r_j + s_val;
            sas_pkg::OP_U2: rd_addr = r_k + s_val;
            sas_pkg::OP_C0: rd_addr = s_v;
            sas_pkg::OP_C1: rd_addr = ~s_v;
            sas_pkg::OP_A0: rd_addr = r_a;
            sas_pkg::OP_A1: rd_addr = s_nib_addr;
            sas_pkg::OP_D0: rd_addr = r_z + r_k;
            sas_pkg::OP_D1: rd_addr = r_i + s_val;
            sas_pkg::OP_D2: rd_addr = r_j + s_val;
            default:        rd_en = 1'b0;
        endcase
        case (i_cmd.op)
            sas_pkg::OP_U3: begin
                wr_en = 1'b1; wr_addr = r_i; wr_data = s_val;
            end
            sas_pkg::OP_U4: begin
                wr_en = 1'b1; wr_addr = r_j; wr_data = r_t;
            end
            sas_pkg::OP_C2: begin
                wr_en = (r_t > s_val); wr_addr = s_v; wr_data = s_val;
            end
            sas_pkg::OP_C3: begin
                wr_en = r_sw; wr_addr = ~s_v; wr_data = r_t;
            end
            sas_pkg::OP_A2: begin
                wr_en = 1'b1; wr_addr = r_a; wr_data = s_val;
            end
            sas_pkg::OP_A3: begin
                wr_en = 1'b1; wr_addr = s_nib_addr; wr_data = r_t;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // permutation memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_mem  <= mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // written flags, cleared at once by reset and reinit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == sas_pkg::OP_INIT) begin
            r_vld <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    // index and scratch registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == sas_pkg::OP_INIT) begin
            r_i <= '0; r_j <= '0; r_k <= '0; r_a <= '0; r_z <= '0;
            r_w <= 8'd1;
        end else begin
            case (i_cmd.op)
                sas_pkg::OP_U0:    r_i <= r_i + r_w;
                sas_pkg::OP_U1:    r_t <= s_val;
                sas_pkg::OP_U2:    r_j <= r_k + s_val;
                sas_pkg::OP_U3:    r_k <= r_i + r_k + s_val;
                sas_pkg::OP_C1:    r_t <= s_val;
                sas_pkg::OP_C2:    r_sw <= (r_t > s_val);
                sas_pkg::OP_A1:    r_t <= s_val;
                sas_pkg::OP_A3:    r_a <= r_a + 8'd1;
                sas_pkg::OP_WSTEP: begin
                    r_w <= r_w + 8'd2;
                    if (i_cmd.a_clr) begin
                        r_a <= '0;
                    end
                end
                sas_pkg::OP_D3: begin
                    r_z <= s_val;
                    r_out <= s_val;
                end
                default: r_sw <= r_sw;
            endcase
        end
    end

    // key latch and loop counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld) begin
            r_key <= i_key_byte;
        end
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 9'd1;
        end
    end

    assign o_sts.a_full     = (r_a == sas_pkg::HALF_IDX);
    assign o_sts.a_zero     = (r_a == 8'd0);
    assign o_sts.whip_last  = (r_cnt == sas_pkg::WHIP_LAST);
    assign o_sts.crush_last = (r_cnt[6:0] == sas_pkg::CRUSH_LAST);
    assign o_random_byte    = r_out;

endmodule

// ===== rtl/sas_ctrl.sv =====
// spritz sequencer: request decode, update/whip/crush/absorb/drip steps
// depends on sas_pkg
`timescale 1ns / 1ps

module sas_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_action,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  sas_pkg::t_sts i_sts,
    output sas_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ACHK = 5'd1;
    localparam logic [4:0] S_DCHK = 5'd2;
    localparam logic [4:0] S_U0   = 5'd3;
    localparam logic [4:0] S_U1   = 5'd4;
    localparam logic [4:0] S_U2   = 5'd5;
    localparam logic [4:0] S_U3   = 5'd6;
    localparam logic [4:0] S_U4   = 5'd7;
    localparam logic [4:0] S_WS   = 5'd8;
    localparam logic [4:0] S_C0   = 5'd9;
    localparam logic [4:0] S_C1   = 5'd10;
    localparam logic [4:0] S_C2   = 5'd11;
    localparam logic [4:0] S_C3   = 5'd12;
    localparam logic [4:0] S_A0   = 5'd13;
    localparam logic [4:0] S_A1   = 5'd14;
    localparam logic [4:0] S_A2   = 5'd15;
    localparam logic [4:0] S_A3   = 5'd16;
    localparam logic [4:0] S_D0   = 5'd17;
    localparam logic [4:0] S_D1   = 5'd18;
    localparam logic [4:0] S_D2   = 5'd19;
    localparam logic [4:0] S_D3   = 5'd20;

    logic [4:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic       r_shuf, n_shuf;
    logic       r_drip, n_drip;
    logic       r_hi, n_hi;
    logic       r_ovld, n_ovld;
    logic       out_free;

    assign out_free = !r_ovld || i_out_ready;
    assign o_out_valid = r_ovld;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_shuf  = r_shuf;
        n_drip  = r_drip;
        n_hi    = r_hi;
        n_ovld  = r_ovld && !i_out_ready;
        o_in_ready = 1'b0;
        o_cmd = '0;
        o_cmd.op = sas_pkg::OP_NOP;
        o_cmd.hi = r_hi;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_action)
                        sas_pkg::ACT_INIT: o_cmd.op = sas_pkg::OP_INIT;
                        sas_pkg::ACT_ABS: begin
                            o_cmd.key_ld = 1'b1;
                            n_hi = 1'b0;
                            n_drip = 1'b0;
                            n_state = S_ACHK;
                        end
                        sas_pkg::ACT_DRIP: begin
                            n_drip = 1'b1;
                            n_state = S_DCHK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ACHK: begin
                if (i_sts.a_full) begin
                    n_shuf = 1'b1; n_phase = '0; o_cmd.cnt_clr = 1'b1; n_state = S_U0;
                end else begin
                    n_state = S_A0;
                end
            end
            S_DCHK: begin
                o_cmd.cnt_clr = 1'b1;
                n_phase = '0;
                n_shuf = !i_sts.a_zero;
                n_state = S_U0;
            end
            S_U0: begin o_cmd.op = sas_pkg::OP_U0; n_state = S_U1; end
            S_U1: begin o_cmd.op = sas_pkg::OP_U1; n_state = S_U2; end
            S_U2: begin o_cmd.op = sas_pkg::OP_U2; n_state = S_U3; end
            S_U3: begin o_cmd.op = sas_pkg::OP_U3; n_state = S_U4; end
            S_U4: begin
                o_cmd.op = sas_pkg::OP_U4;
                if (!r_shuf) begin
                    n_state = S_D0;
                end else if (i_sts.whip_last) begin
                    n_state = S_WS;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_U0;
                end
            end
            // end of a whip: advance w, then crush or leave the shuffle
            S_WS: begin
                o_cmd.op = sas_pkg::OP_WSTEP;
                o_cmd.cnt_clr = 1'b1;
                if (r_phase == sas_pkg::PHASE_LAST) begin
                    o_cmd.a_clr = 1'b1;
                    n_shuf = 1'b0;
                    n_state = r_drip ? S_U0 : S_A0;
                end else begin
                    n_phase = r_phase + 3'd2;
                    n_state = S_C0;
                end
            end
            S_C0: begin o_cmd.op = sas_pkg::OP_C0; n_state = S_C1; end
            S_C1: begin o_cmd.op = sas_pkg::OP_C1; n_state = S_C2; end
            S_C2: begin o_cmd.op = sas_pkg::OP_C2; n_state = S_C3; end
            S_C3: begin
                o_cmd.op = sas_pkg::OP_C3;
                if (i_sts.crush_last) begin
                    o_cmd.cnt_clr = 1'b1; n_state = S_U0;
                end else begin
                    o_cmd.cnt_inc = 1'b1; n_state = S_C0;
                end
            end
            S_A0: begin o_cmd.op = sas_pkg::OP_A0; n_state = S_A1; end
            S_A1: begin o_cmd.op = sas_pkg::OP_A1; n_state = S_A2; end
            S_A2: begin o_cmd.op = sas_pkg::OP_A2; n_state = S_A3; end
            S_A3: begin
                o_cmd.op = sas_pkg::OP_A3;
                if (!r_hi) begin
                    n_hi = 1'b1; n_state = S_ACHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_D0: begin o_cmd.op = sas_pkg::OP_D0; n_state = S_D1; end
            S_D1: begin o_cmd.op = sas_pkg::OP_D1; n_state = S_D2; end
            S_D2: begin o_cmd.op = sas_pkg::OP_D2; n_state = S_D3; end
            // hold the byte until the output register is free
            S_D3: begin
                if (out_free) begin
                    o_cmd.op = sas_pkg::OP_D3;
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_shuf  <= 1'b0;
            r_drip  <= 1'b0;
            r_hi    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_shuf  <= n_shuf;
            r_drip  <= n_drip;
            r_hi    <= n_hi;
            r_ovld  <= n_ovld;
        end
    end

endmodule

// ===== rtl/spritz_absorb_squeeze_unit.sv =====
// channel   | dir | payload              | beat when
// i_in      | in  | action, key_byte     | valid && ready
// o_out     | out | random_byte          | valid && ready
//
// one request at a time; every memory step is one read or one write of the
// single-port 256x8 permutation ram, so an update runs through the steps U0 to U4
// drip: idle, check, update, 4 output steps; absorb: idle plus two nibbles
// of a check and 4 steps each
// a shuffle adds 3 x 512 updates, 3 w steps and 2 x 128 crush steps
// reset and reinit take effect at once through per-entry written flags
// a drip result waits in an output register; with a stalled sink the unit
// keeps going until the next drip reaches its output step, then all input waits
// depends on sas_pkg, sas_if, sas_ctrl, sas_dpath
`timescale 1ns / 1ps

module spritz_absorb_squeeze_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sas_in_if.sink    i_in,
    sas_out_if.source o_out
);

    sas_pkg::t_cmd cmd;
    sas_pkg::t_sts sts;

    // sequencer
    sas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // memory and registers
    sas_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key_byte    (i_in.key_byte),
        .o_sts         (sts),
        .o_random_byte (o_out.random_byte)
    );

endmodule

// ===== rtl/sas_chk.sv =====
// port-level checker for the spritz unit, bound to the top level
// depends on sas_pkg and spritz_absorb_squeeze_unit_assert.svh
`timescale 1ns / 1ps
`include "spritz_absorb_squeeze_unit_assert.svh"

module sas_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_random_byte
);

    // a pending byte stays put until taken
    `SAS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_random_byte))
    // nothing is offered right after reset
    `SAS_ASSERT_NEXT_RST(a_rst_quiet, !i_rst_n, !i_out_valid)
    // only a drip produces a byte
    `SAS_ASSERT_NEXT(a_no_spurious, i_in_valid && i_in_ready && i_action != sas_pkg::ACT_DRIP && !i_out_valid, !i_out_valid)
    // a drip keeps the unit busy
    `SAS_ASSERT_NEXT(a_drip_busy, i_in_valid && i_in_ready && i_action == sas_pkg::ACT_DRIP, !i_in_ready)

endmodule

bind spritz_absorb_squeeze_unit sas_chk u_sas_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_action      (i_in.action),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_random_byte (o_out.random_byte)
);
